/* rtl/irpd_pkg.sv */
// Shared types, constants and register codes for the infrared pulse-distance frame decoder.
package irpd_pkg;

  localparam int unsigned TIMER_BITS = 32;
  localparam int unsigned EDGE_W     = 32;
  localparam int unsigned STAMP_W    = (TIMER_BITS < EDGE_W) ? TIMER_BITS : EDGE_W;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned CNT_W      = $clog2(FRAME_BITS);
  localparam int unsigned HELD_W     = 6;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] LEADER_MIN_RST = CFG_W'(13000);
  localparam logic [CFG_W-1:0] LEADER_MAX_RST = CFG_W'(14000);
  localparam logic [CFG_W-1:0] ZERO_MIN_RST   = CFG_W'(800);
  localparam logic [CFG_W-1:0] ZERO_MAX_RST   = CFG_W'(1500);
  localparam logic [CFG_W-1:0] ONE_MIN_RST    = CFG_W'(2000);
  localparam logic [CFG_W-1:0] ONE_MAX_RST    = CFG_W'(5000);

  typedef enum logic [2:0] {
    CLS_FIRST   = 3'd0,
    CLS_LEADER  = 3'd1,
    CLS_ZERO    = 3'd2,
    CLS_ONE     = 3'd3,
    CLS_INVALID = 3'd4
  } class_e;

  typedef enum logic [IDX_W-1:0] {
    REG_LEADER_MIN = 3'd0,
    REG_LEADER_MAX = 3'd1,
    REG_ZERO_MIN   = 3'd2,
    REG_ZERO_MAX   = 3'd3,
    REG_ONE_MIN    = 3'd4,
    REG_ONE_MAX    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] leader_min;
    logic [CFG_W-1:0] leader_max;
    logic [CFG_W-1:0] zero_min;
    logic [CFG_W-1:0] zero_max;
    logic [CFG_W-1:0] one_min;
    logic [CFG_W-1:0] one_max;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [CMP_W-1:0] cmp_t;

endpackage

/* rtl/ir_pulse_distance_frame_decoder_top.sv */
// Top level of the infrared pulse-distance frame decoder.
// An edge beat is classified in the cycle it is accepted; its class is written into the queue,
// and the result register takes it from there once that register is empty or being read.
// Throughput is one beat per cycle while results are taken; a full queue holds edge_ready_o low.
// Reset clears the stamp tracking, the bit collection and the queue, and loads the default windows.
module ir_pulse_distance_frame_decoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [irpd_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [irpd_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          edge_valid_i,
  output logic                          edge_ready_o,
  input  logic [irpd_pkg::EDGE_W-1:0]   edge_time_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [2:0]                    interval_class_o,
  output logic [irpd_pkg::HELD_W-1:0]   bits_held_o,
  output logic                          frame_ready_o,
  output logic                          frame_valid_o,
  output logic [irpd_pkg::BYTE_W-1:0]   address_o,
  output logic [irpd_pkg::BYTE_W-1:0]   command_o
);
  import irpd_pkg::*;

  q_stat_t q_stat;
  logic    push, pop;
  class_e  push_class, pop_class;

  irpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .edge_valid_i (edge_valid_i),
    .edge_ready_o (edge_ready_o),
    .edge_time_i  (edge_time_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_class_o (push_class)
  );

  irpd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_class_i (push_class),
    .pop_i        (pop),
    .pop_class_o  (pop_class),
    .stat_o       (q_stat)
  );

  irpd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_stat_i         (q_stat),
    .q_class_i        (pop_class),
    .pop_o            (pop),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .interval_class_o (interval_class_o),
    .bits_held_o      (bits_held_o),
    .frame_ready_o    (frame_ready_o),
    .frame_valid_o    (frame_valid_o),
    .address_o        (address_o),
    .command_o        (command_o)
  );

  a_frame_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && frame_ready_o) |->
      (bits_held_o == HELD_W'(FRAME_BITS)) &&
      ((interval_class_o == CLS_ZERO) || (interval_class_o == CLS_ONE)))
    else $error("completed frame without a full bit count");

  a_no_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !frame_ready_o) |->
      (!frame_valid_o && (address_o == '0) && (command_o == '0)))
    else $error("frame fields set without a completed frame");

  a_restart_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && ((interval_class_o == CLS_FIRST) || (interval_class_o == CLS_INVALID))) |->
      (bits_held_o == '0))
    else $error("bits held after a first edge or a restart");

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty) && !(pop && q_stat.empty))
    else $error("class queue status inconsistent");

endmodule

/* rtl/irpd_front.sv */
// Front end: window registers, edge stamp tracking and interval classification.
module irpd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [irpd_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [irpd_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          edge_valid_i,
  output logic                          edge_ready_o,
  input  logic [irpd_pkg::EDGE_W-1:0]   edge_time_i,
  input  irpd_pkg::q_stat_t             q_stat_i,
  output logic                          push_o,
  output irpd_pkg::class_e              push_class_o
);
  import irpd_pkg::*;

  cfg_t               cfg_q, cfg_d;
  logic [STAMP_W-1:0] last_q, last_d;
  logic               have_q, have_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [STAMP_W-1:0] now;
  logic [TIMER_BITS-1:0] interval;
  cmp_t               iv;
  logic               in_leader, in_zero, in_one;
  class_e             cls;

  assign edge_ready_o = !q_stat_i.full;
  assign push_o       = edge_valid_i && edge_ready_o;
  assign push_class_o = cls;

  assign now      = edge_time_i[STAMP_W-1:0];
  assign interval = TIMER_BITS'(last_q) - TIMER_BITS'(now);
  assign iv       = CMP_W'(interval);

  assign in_leader = (iv >= CMP_W'(cfg_q.leader_min)) && (iv <= CMP_W'(cfg_q.leader_max));
  assign in_zero   = (iv >= CMP_W'(cfg_q.zero_min)) && (iv <= CMP_W'(cfg_q.zero_max));
  assign in_one    = (iv >= CMP_W'(cfg_q.one_min)) && (iv <= CMP_W'(cfg_q.one_max));

  always_comb begin
    if (!have_q) begin
      cls = CLS_FIRST;
    end else if (in_leader) begin
      cls = CLS_LEADER;
    end else if (in_zero) begin
      cls = CLS_ZERO;
    end else if (in_one) begin
      cls = CLS_ONE;
    end else begin
      cls = CLS_INVALID;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LEADER_MIN: cfg_d.leader_min = cfg_wdata_i;
        REG_LEADER_MAX: cfg_d.leader_max = cfg_wdata_i;
        REG_ZERO_MIN:   cfg_d.zero_min   = cfg_wdata_i;
        REG_ZERO_MAX:   cfg_d.zero_max   = cfg_wdata_i;
        REG_ONE_MIN:    cfg_d.one_min    = cfg_wdata_i;
        REG_ONE_MAX:    cfg_d.one_max    = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  // The bit count is mirrored here so that a completed frame restarts the stamp tracking.
  always_comb begin
    last_d = last_q;
    have_d = have_q;
    cnt_d  = cnt_q;
    if (push_o) begin
      last_d = now;
      have_d = 1'b1;
      case (cls)
        CLS_INVALID: begin
          have_d = 1'b0;
          cnt_d  = '0;
        end
        CLS_ZERO, CLS_ONE: begin
          if (cnt_q == CNT_W'(FRAME_BITS - 1)) begin
            have_d = 1'b0;
            cnt_d  = '0;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        default: cnt_d = cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_min <= LEADER_MIN_RST;
      cfg_q.leader_max <= LEADER_MAX_RST;
      cfg_q.zero_min   <= ZERO_MIN_RST;
      cfg_q.zero_max   <= ZERO_MAX_RST;
      cfg_q.one_min    <= ONE_MIN_RST;
      cfg_q.one_max    <= ONE_MAX_RST;
      last_q           <= '0;
      have_q           <= 1'b0;
      cnt_q            <= '0;
    end else begin
      cfg_q  <= cfg_d;
      last_q <= last_d;
      have_q <= have_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* rtl/irpd_queue.sv */
// Two-entry queue of interval classes between the front end and the frame assembler.
module irpd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  irpd_pkg::class_e  push_class_i,
  input  logic              pop_i,
  output irpd_pkg::class_e  pop_class_o,
  output irpd_pkg::q_stat_t stat_o
);
  import irpd_pkg::*;

  class_e              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_class_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_class_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/irpd_back.sv */
// Back end: bit shift register, frame completion checks and the result register.
module irpd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  irpd_pkg::q_stat_t             q_stat_i,
  input  irpd_pkg::class_e              q_class_i,
  output logic                          pop_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [2:0]                    interval_class_o,
  output logic [irpd_pkg::HELD_W-1:0]   bits_held_o,
  output logic                          frame_ready_o,
  output logic                          frame_valid_o,
  output logic [irpd_pkg::BYTE_W-1:0]   address_o,
  output logic [irpd_pkg::BYTE_W-1:0]   command_o
);
  import irpd_pkg::*;

  logic [FRAME_BITS-1:0] shift_q, shift_d, shift_n;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [HELD_W-1:0]     held_n;
  logic                  vld_q, vld_d;
  class_e                cls_q;
  logic [HELD_W-1:0]     held_q;
  logic                  rdy_q, rdy_n;
  logic                  fval_q, fval_n;
  logic [BYTE_W-1:0]     addr_q, addr_n, cmd_q, cmd_n;

  assign pop_o = !q_stat_i.empty && (!vld_q || res_ready_i);

  always_comb begin
    shift_n = shift_q;
    held_n  = HELD_W'(cnt_q);
    case (q_class_i)
      CLS_INVALID: begin
        shift_n = '0;
        held_n  = '0;
      end
      CLS_ZERO, CLS_ONE: begin
        shift_n = {shift_q[FRAME_BITS-2:0], (q_class_i == CLS_ONE)};
        held_n  = HELD_W'(cnt_q) + HELD_W'(1);
      end
      default: held_n = HELD_W'(cnt_q);
    endcase
    rdy_n  = (held_n == HELD_W'(FRAME_BITS));
    fval_n = 1'b0;
    addr_n = '0;
    cmd_n  = '0;
    shift_d = shift_n;
    cnt_d   = held_n[CNT_W-1:0];
    if (rdy_n) begin
      fval_n  = ((shift_n[31:24] ^ shift_n[23:16]) == 8'hFF) &&
                ((shift_n[15:8] ^ shift_n[7:0]) == 8'hFF);
      addr_n  = shift_n[31:24];
      cmd_n   = shift_n[15:8];
      shift_d = '0;
      cnt_d   = '0;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (pop_o) begin
      vld_d = 1'b1;
    end else if (res_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cls_q  <= q_class_i;
      held_q <= held_n;
      rdy_q  <= rdy_n;
      fval_q <= fval_n;
      addr_q <= addr_n;
      cmd_q  <= cmd_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (pop_o) begin
        shift_q <= shift_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  assign res_valid_o      = vld_q;
  assign interval_class_o = cls_q;
  assign bits_held_o      = held_q;
  assign frame_ready_o    = rdy_q;
  assign frame_valid_o    = fval_q;
  assign address_o        = addr_q;
  assign command_o        = cmd_q;

endmodule

/* bench/ir_pulse_distance_frame_decoder_top_tb.sv */
// Self-checking testbench for the infrared pulse-distance frame decoder top level.
module ir_pulse_distance_frame_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import irpd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned PRINT_MAX    = 40;

  typedef struct packed {
    logic [EDGE_W-1:0] stamp;
    logic              typed;
    class_e            cls;
    logic [HELD_W-1:0] held;
  } edge_row_t;

  typedef struct packed {
    class_e            cls;
    logic [HELD_W-1:0] held;
    logic              ready;
    logic              valid;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] cmd;
  } frame_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_W-1:0]    cfg_wdata_i = '0;
  logic                edge_valid_i = 1'b0;
  logic                edge_ready_o;
  logic [EDGE_W-1:0]   edge_time_i = '0;
  logic                res_valid_o;
  logic                res_ready_i = 1'b0;
  logic [2:0]          interval_class_o;
  logic [HELD_W-1:0]   bits_held_o;
  logic                frame_ready_o;
  logic                frame_valid_o;
  logic [BYTE_W-1:0]   address_o;
  logic [BYTE_W-1:0]   command_o;

  ir_pulse_distance_frame_decoder_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .edge_valid_i     (edge_valid_i),
    .edge_ready_o     (edge_ready_o),
    .edge_time_i      (edge_time_i),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .interval_class_o (interval_class_o),
    .bits_held_o      (bits_held_o),
    .frame_ready_o    (frame_ready_o),
    .frame_valid_o    (frame_valid_o),
    .address_o        (address_o),
    .command_o        (command_o)
  );

  edge_row_t edge_tab [24] = '{
    '{32'hFFFFFFFF, 1'b1, CLS_FIRST,   6'd0},
    '{32'hFFFFCD37, 1'b0, CLS_LEADER,  6'd0},
    '{32'hFFFF9687, 1'b0, CLS_LEADER,  6'd0},
    '{32'hFFFF9367, 1'b0, CLS_ZERO,    6'd1},
    '{32'hFFFF8D8B, 1'b0, CLS_ZERO,    6'd2},
    '{32'hFFFF85BB, 1'b0, CLS_ONE,     6'd3},
    '{32'hFFFF7233, 1'b0, CLS_ONE,     6'd4},
    '{32'hFFFF3D77, 1'b0, CLS_LEADER,  6'd4},
    '{32'hFFFF3A58, 1'b1, CLS_INVALID, 6'd0},
    '{32'h00000000, 1'b1, CLS_FIRST,   6'd0},
    '{32'hFFFFFC18, 1'b0, CLS_ZERO,    6'd1},
    '{32'hFFFFF63B, 1'b1, CLS_INVALID, 6'd0},
    '{32'h12345678, 1'b1, CLS_FIRST,   6'd0},
    '{32'h12344EA9, 1'b1, CLS_INVALID, 6'd0},
    '{32'h80000000, 1'b1, CLS_FIRST,   6'd0},
    '{32'h80000000, 1'b1, CLS_INVALID, 6'd0},
    '{32'h00000000, 1'b1, CLS_FIRST,   6'd0},
    '{32'h00000001, 1'b1, CLS_INVALID, 6'd0},
    '{32'h5A5A5A5A, 1'b1, CLS_FIRST,   6'd0},
    '{32'h5A5A46D1, 1'b1, CLS_INVALID, 6'd0},
    '{32'hA5A5A5A5, 1'b1, CLS_FIRST,   6'd0},
    '{32'hA5A56EF4, 1'b1, CLS_INVALID, 6'd0},
    '{32'h0000FFFF, 1'b1, CLS_FIRST,   6'd0},
    '{32'h0000F05F, 1'b0, CLS_ONE,     6'd1}
  };

  cfg_t              dec_win;
  logic [EDGE_W-1:0] prev_stamp;
  logic              seen_edge;
  logic [HELD_W-1:0] bit_cnt;
  logic [31:0]       bit_shift;

  edge_row_t  edge_q [$];
  frame_res_t decoded_q [$];
  edge_row_t  shown_row;
  frame_res_t got_res;
  frame_res_t want_res;

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;
  int unsigned rdy_left = 0;
  int unsigned stall_left = 0;

  function automatic frame_res_t decode_edge(logic [EDGE_W-1:0] stamp);
    frame_res_t r;
    logic [EDGE_W-1:0] span;
    r = '0;
    if (!seen_edge) begin
      seen_edge  = 1'b1;
      prev_stamp = stamp;
      r.cls      = CLS_FIRST;
    end else begin
      span       = prev_stamp - stamp;
      prev_stamp = stamp;
      if (span >= dec_win.leader_min && span <= dec_win.leader_max) begin
        r.cls = CLS_LEADER;
      end else if (span >= dec_win.zero_min && span <= dec_win.zero_max) begin
        r.cls = CLS_ZERO;
      end else if (span >= dec_win.one_min && span <= dec_win.one_max) begin
        r.cls = CLS_ONE;
      end else begin
        r.cls = CLS_INVALID;
      end
      if (r.cls == CLS_INVALID) begin
        seen_edge = 1'b0;
        bit_cnt   = '0;
        bit_shift = '0;
      end else if (r.cls != CLS_LEADER) begin
        bit_shift = {bit_shift[30:0], r.cls == CLS_ONE};
        bit_cnt   = bit_cnt + HELD_W'(1);
      end
    end
    r.held = bit_cnt;
    if (bit_cnt >= HELD_W'(FRAME_BITS)) begin
      r.ready   = 1'b1;
      r.valid   = ((bit_shift[31:24] ^ bit_shift[23:16]) == 8'hFF) &&
                  ((bit_shift[15:8] ^ bit_shift[7:0]) == 8'hFF);
      r.addr    = bit_shift[31:24];
      r.cmd     = bit_shift[15:8];
      r.held    = HELD_W'(FRAME_BITS);
      seen_edge = 1'b0;
      bit_cnt   = '0;
      bit_shift = '0;
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_span(logic [31:0] lo, logic [31:0] hi);
    if (lo > hi) begin
      return $urandom;
    end
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic void queue_stamp(logic [EDGE_W-1:0] s);
    edge_row_t row;
    row = '0;
    row.stamp = s;
    edge_q.push_back(row);
  endfunction

  task automatic queue_frames(int unsigned n);
    int unsigned target;
    int unsigned nbits;
    logic [31:0] s;
    logic [31:0] payload;
    logic [7:0]  a;
    logic [7:0]  c;
    target = edge_q.size() + n;
    while (edge_q.size() < target) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 3)) queue_stamp($urandom);
      end
      s = $urandom;
      queue_stamp(s);
      repeat (($urandom_range(0, 4) == 0) ? 2 : 1) begin
        if (dec_win.leader_min <= dec_win.leader_max && $urandom_range(0, 9) != 0) begin
          s = s - pick_span(dec_win.leader_min, dec_win.leader_max);
          queue_stamp(s);
        end
      end
      a = 8'($urandom);
      c = 8'($urandom);
      payload = ($urandom_range(0, 3) != 0) ? {a, ~a, c, ~c} : $urandom;
      if ($urandom_range(0, 7) == 0) begin
        payload[$urandom_range(0, 31)] ^= 1'b1;
      end
      nbits = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 31) : 32;
      for (int i = 31; i > 31 - int'(nbits); i--) begin
        if ($urandom_range(0, 49) == 0) begin
          s = s - $urandom;
        end else if (payload[i]) begin
          s = s - pick_span(dec_win.one_min, dec_win.one_max);
        end else begin
          s = s - pick_span(dec_win.zero_min, dec_win.zero_max);
        end
        queue_stamp(s);
      end
    end
  endtask

  task automatic drain_all();
    while (edge_q.size() != 0 || edge_valid_i || decoded_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apply_windows(cfg_t w);
    reg_idx_e    idx [6];
    logic [31:0] val [6];
    idx = '{REG_LEADER_MIN, REG_LEADER_MAX, REG_ZERO_MIN, REG_ZERO_MAX,
            REG_ONE_MIN, REG_ONE_MAX};
    val = '{w.leader_min, w.leader_max, w.zero_min, w.zero_max, w.one_min, w.one_max};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= val[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dec_win = w;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_MAX) begin
      $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $realtime, what, got, want);
    end
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (edge_valid_i && edge_ready_o) begin
        got_res = decode_edge(edge_time_i);
        if (shown_row.typed) begin
          got_res      = '0;
          got_res.cls  = shown_row.cls;
          got_res.held = shown_row.held;
        end
        decoded_q.push_back(got_res);
      end
      if (!edge_valid_i || edge_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          edge_valid_i <= 1'b0;
        end else if (edge_q.size() != 0) begin
          shown_row = edge_q.pop_front();
          edge_valid_i <= 1'b1;
          edge_time_i  <= shown_row.stamp;
          burst_left--;
          if (burst_left == 0) begin
            gap_left   = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 15);
          end
        end else begin
          edge_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o && res_ready_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(interval_class_o), 0);
        end else begin
          want_res = decoded_q.pop_front();
          if (interval_class_o !== want_res.cls)
            report_mismatch("interval_class", 32'(interval_class_o), 32'(want_res.cls));
          if (bits_held_o !== want_res.held)
            report_mismatch("bits_held", 32'(bits_held_o), 32'(want_res.held));
          if (frame_ready_o !== want_res.ready)
            report_mismatch("frame_ready", 32'(frame_ready_o), 32'(want_res.ready));
          if (frame_valid_o !== want_res.valid)
            report_mismatch("frame_valid", 32'(frame_valid_o), 32'(want_res.valid));
          if (address_o !== want_res.addr)
            report_mismatch("address", 32'(address_o), 32'(want_res.addr));
          if (command_o !== want_res.cmd)
            report_mismatch("command", 32'(command_o), 32'(want_res.cmd));
        end
      end
      if (rdy_left == 0 && stall_left == 0) begin
        rdy_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 12);
        stall_left = $urandom_range(1, 4);
      end
      if (rdy_left > 0) begin
        rdy_left--;
        res_ready_i <= 1'b1;
      end else begin
        stall_left--;
        res_ready_i <= 1'b0;
      end
    end
  end

  initial begin
    cfg_t w;
    dec_win    = '{LEADER_MIN_RST, LEADER_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
                   ONE_MIN_RST, ONE_MAX_RST};
    prev_stamp = '0;
    seen_edge  = 1'b0;
    bit_cnt    = '0;
    bit_shift  = '0;
    shown_row  = '0;
    while (!rst_ni) @(posedge clk_i);

    foreach (edge_tab[i]) edge_q.push_back(edge_tab[i]);
    queue_frames(600);
    drain_all();

    w = '{32'd1000, 32'd3000, 32'd0, 32'd2000, 32'd1500, 32'hFFFFFFFF};
    apply_windows(w);
    queue_frames(350);
    drain_all();

    w = '{32'hFFFFFF00, 32'hFFFFFFFF, 32'd1, 32'd1, 32'd2, 32'd2};
    apply_windows(w);
    queue_frames(300);
    drain_all();

    w = '{32'd14000, 32'd13000, 32'd800, 32'd1500, 32'd2000, 32'd5000};
    apply_windows(w);
    queue_frames(400);
    drain_all();

    w = '{32'd0, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF};
    apply_windows(w);
    queue_frames(100);
    drain_all();

    w = '{LEADER_MIN_RST, LEADER_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
          ONE_MIN_RST, ONE_MAX_RST};
    apply_windows(w);
    queue_frames(250);
    drain_all();

    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
